// File: hw/rtl/fgpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgpr_pkg
// Shared types, constants and glyph selection for the 5x7 character renderer.
// ----------------------------------------------------------------------------
package fgpr_pkg;

    // Field widths
    localparam int COORD_W  = 10;
    localparam int ORIGIN_W = 16;
    localparam int POS_W    = 12;
    localparam int CODE_W   = 8;
    localparam int COLOR_W  = 16;
    localparam int SIZE_W   = 2;
    localparam int WIDE_W   = 18;   // holds origin + pos * pitch without wrap

    // Stream packing
    localparam int S_TDATA_W = 88;  // 84 bits of fields padded to whole bytes
    localparam int M_TDATA_W = 40;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 10'd240;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 10'd320;

    // Lowest origin accepted in normal mode; a lower one skips the character
    localparam int MIN_ORIGIN_X = -30;
    localparam int MIN_ORIGIN_Y = -7;

    // Glyph geometry
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COUNT = 54;
    localparam int GLYPH_IDX_W = 6;
    localparam int COL_W       = 3;
    localparam int ROW_W       = 3;

    // Glyph groups inside the font memory
    localparam logic [GLYPH_IDX_W-1:0] DIGIT_BASE = 6'd26;
    localparam logic [GLYPH_IDX_W-1:0] SPACE_IDX  = 6'd36;
    localparam logic [GLYPH_IDX_W-1:0] COLON_IDX  = 6'd52;
    localparam logic [GLYPH_IDX_W-1:0] SEMI_IDX   = 6'd53;

    // One glyph: five column bytes, column 0 in the top byte
    typedef logic [8*GLYPH_COLS-1:0] t_glyph_bits;

    typedef struct packed {
        logic                   hit;
        logic [GLYPH_IDX_W-1:0] idx;
    } t_glyph_sel;

    // Map a character code to its font entry; lowercase folds to uppercase
    function automatic t_glyph_sel glyph_lookup(input logic [CODE_W-1:0] code,
                                                input logic dbl);
        t_glyph_sel sel;
        sel.hit = 1'b1;
        sel.idx = SPACE_IDX;
        if (code >= 8'd65 && code <= 8'd90) begin
            sel.idx = GLYPH_IDX_W'(code - 8'd65);
        end else if (code >= 8'd97 && code <= 8'd122) begin
            sel.idx = GLYPH_IDX_W'(code - 8'd97);
        end else if (code >= 8'd48 && code <= 8'd57) begin
            sel.idx = DIGIT_BASE + GLYPH_IDX_W'(code - 8'd48);
        end else if (dbl) begin
            sel.hit = (code == 8'd32);
        end else if (code >= 8'd32 && code <= 8'd47) begin
            sel.idx = SPACE_IDX + GLYPH_IDX_W'(code - 8'd32);
        end else if (code == 8'd58) begin
            sel.idx = COLON_IDX;
        end else if (code == 8'd59) begin
            sel.idx = SEMI_IDX;
        end
        return sel;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/font_glyph_to_pixel_renderer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// font_glyph_to_pixel_renderer_top
// Renders one 5x7 character per input transfer as clipped 1x1 or 2x2
// rectangle writes, column by column and row by row.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                         side band
//  s_axis    in         origin_x, origin_y, char_pos, char_code,   tuser: mode
//                       fore_color, back_color, 4 zero bits
//  m_axis    out        rect_x, rect_y, rect_w, rect_h,             tlast: last
//                       fill_color
//  cfg       in         write enable, index, 10-bit data            -
//
//  A drawn character occupies the cell scan sequencer, one glyph cell per
//  cycle unless a stalled output holds it; a skipped character leaves the
//  setup register unscanned. A write passes setup, scan and output registers.
//  The next character is set up (font memory read included) during the scan.
//  Reset clears all valid flags and loads 240 x 320 into the screen size.
//  A stalled output holds the scan on the current cell.
// ----------------------------------------------------------------------------
module font_glyph_to_pixel_renderer_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input items
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // origin_x, origin_y, char_pos, char_code, fore_color, back_color, pad
    input  wire logic [fgpr_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                          i_s_axis_tuser,   // mode
    // rectangle writes
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, fill_color
    output logic [fgpr_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast,   // last
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [fgpr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fgpr_pkg::COORD_W-1:0]  i_cfg_data
);
    import fgpr_pkg::*;

    // Font memory, one glyph per entry, column 0 in the top byte
    localparam t_glyph_bits GLYPH_ROM [GLYPH_COUNT] = '{
        40'h7C1211127C, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
        40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
        40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
        40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E,
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h0036360000, 40'h0056360000
    };

    // Screen size registers
    logic [COORD_W-1:0] r_sw;
    logic [COORD_W-1:0] r_sh;

    // Setup stage
    logic                      r_b_valid;
    logic                      r_b_skip;
    logic                      r_b_dbl;
    logic signed [WIDE_W-1:0]  r_b_base_x;
    logic signed [WIDE_W-1:0]  r_b_oy;
    logic [COLOR_W-1:0]        r_b_fg;
    logic [COLOR_W-1:0]        r_b_bg;
    t_glyph_bits               r_b_glyph;

    // Scan stage
    logic                      r_c_busy;
    logic [COL_W-1:0]          r_col;
    logic [ROW_W-1:0]          r_row;
    logic                      r_c_dbl;
    logic [COORD_W-1:0]        r_c_x0;
    logic [COORD_W-1:0]        r_c_y0;
    logic [COLOR_W-1:0]        r_c_fg;
    logic [COLOR_W-1:0]        r_c_bg;
    t_glyph_bits               r_c_glyph;
    logic [GLYPH_COLS-1:0]     r_col_ok;
    logic [GLYPH_COLS-1:0]     r_col_cut;
    logic [GLYPH_COLS-1:0]     r_col_last;
    logic [GLYPH_ROWS-1:0]     r_row_ok;
    logic [GLYPH_ROWS-1:0]     r_row_cut;
    logic [GLYPH_ROWS-1:0]     r_row_last;

    // Output register
    logic                      r_o_valid;
    logic [M_TDATA_W-1:0]      r_o_data;
    logic                      r_o_last;

    // Input field views
    logic                      w_in_dbl;
    logic signed [WIDE_W-1:0]  w_in_ox;
    logic signed [WIDE_W-1:0]  w_in_oy;
    logic [POS_W-1:0]          w_in_pos;
    logic [CODE_W-1:0]         w_in_code;
    t_glyph_sel                w_sel;
    logic [ORIGIN_W-1:0]       w_pitch_off;
    logic                      w_origin_bad;
    logic signed [WIDE_W-1:0]  w_sw;
    logic signed [WIDE_W-1:0]  w_sh;

    // Handshake and sequencing
    logic                      w_s_take;
    logic                      w_b_take;
    logic                      w_b_load_c;
    logic                      w_out_free;
    logic                      w_kept;
    logic                      w_step;
    logic                      w_scan_end;

    // Clip masks for the next character
    logic [GLYPH_COLS-1:0]     n_col_ok;
    logic [GLYPH_COLS-1:0]     n_col_cut;
    logic [GLYPH_COLS-1:0]     n_col_last;
    logic [GLYPH_ROWS-1:0]     n_row_ok;
    logic [GLYPH_ROWS-1:0]     n_row_cut;
    logic [GLYPH_ROWS-1:0]     n_row_last;

    // Current cell
    logic [7:0]                w_col_byte;
    logic [COORD_W-1:0]        w_px;
    logic [COORD_W-1:0]        w_py;
    logic [SIZE_W-1:0]         w_rw;
    logic [SIZE_W-1:0]         w_rh;
    logic [COLOR_W-1:0]        w_color;

    assign w_sw = $signed({{(WIDE_W-COORD_W){1'b0}}, r_sw});
    assign w_sh = $signed({{(WIDE_W-COORD_W){1'b0}}, r_sh});

    // Unpack the input transfer
    assign w_in_dbl  = i_s_axis_tuser;
    assign w_in_ox   = WIDE_W'($signed(i_s_axis_tdata[15:0]));
    assign w_in_oy   = WIDE_W'($signed(i_s_axis_tdata[31:16]));
    assign w_in_pos  = i_s_axis_tdata[43:32];
    assign w_in_code = i_s_axis_tdata[51:44];
    assign w_sel     = glyph_lookup(w_in_code, w_in_dbl);

    // Cell pitch times position: 12 = 8 + 4, 6 = 4 + 2
    assign w_pitch_off = w_in_dbl
        ? ORIGIN_W'({w_in_pos, 3'b000}) + ORIGIN_W'({w_in_pos, 2'b00})
        : ORIGIN_W'({w_in_pos, 2'b00})  + ORIGIN_W'({w_in_pos, 1'b0});

    assign w_origin_bad = !w_in_dbl &&
        (w_in_ox >= w_sw || w_in_oy >= w_sh ||
         w_in_ox < $signed(WIDE_W'(MIN_ORIGIN_X)) ||
         w_in_oy < $signed(WIDE_W'(MIN_ORIGIN_Y)));

    // Pipeline handshakes
    assign w_out_free = !r_o_valid || i_m_axis_tready;
    assign w_kept     = r_col_ok[r_col] && r_row_ok[r_row];
    assign w_step     = r_c_busy && (!w_kept || w_out_free);
    assign w_scan_end = w_step && r_col == COL_W'(GLYPH_COLS - 1) &&
                        r_row == ROW_W'(GLYPH_ROWS - 1);
    assign w_b_load_c = r_b_valid && !r_b_skip && (!r_c_busy || w_scan_end);
    assign w_b_take   = (r_b_valid && r_b_skip) || w_b_load_c;
    assign w_s_take   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_b_valid || w_b_take;

    // Clip each column and row of the character waiting in setup
    always_comb begin
        logic signed [WIDE_W-1:0] v_off;
        logic signed [WIDE_W-1:0] v_p;
        n_col_ok   = '0;
        n_col_cut  = '0;
        n_col_last = '0;
        n_row_ok   = '0;
        n_row_cut  = '0;
        n_row_last = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            v_off = r_b_dbl ? $signed(WIDE_W'(c * 2)) : $signed(WIDE_W'(c));
            v_p   = r_b_base_x + v_off;
            n_col_ok[c]  = v_p >= $signed(WIDE_W'(0)) && v_p < w_sw;
            n_col_cut[c] = v_p == w_sw - $signed(WIDE_W'(1));
            if (n_col_ok[c]) begin
                n_col_last = GLYPH_COLS'(1) << c;
            end
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            v_off = r_b_dbl ? $signed(WIDE_W'(r * 2)) : $signed(WIDE_W'(r));
            v_p   = r_b_oy + v_off;
            n_row_ok[r]  = v_p >= $signed(WIDE_W'(0)) && v_p < w_sh;
            n_row_cut[r] = v_p == w_sh - $signed(WIDE_W'(1));
            if (n_row_ok[r]) begin
                n_row_last = GLYPH_ROWS'(1) << r;
            end
        end
    end

    // Pick the glyph column under scan
    always_comb begin
        case (r_col)
            3'd0:    w_col_byte = r_c_glyph[39:32];
            3'd1:    w_col_byte = r_c_glyph[31:24];
            3'd2:    w_col_byte = r_c_glyph[23:16];
            3'd3:    w_col_byte = r_c_glyph[15:8];
            3'd4:    w_col_byte = r_c_glyph[7:0];
            default: w_col_byte = '0;
        endcase
    end

    // Form the write for the current cell
    assign w_px = r_c_x0 + (r_c_dbl ? COORD_W'({r_col, 1'b0}) : COORD_W'(r_col));
    assign w_py = r_c_y0 + (r_c_dbl ? COORD_W'({r_row, 1'b0}) : COORD_W'(r_row));
    assign w_rw = (r_c_dbl && !r_col_cut[r_col]) ? SIZE_W'(2) : SIZE_W'(1);
    assign w_rh = (r_c_dbl && !r_row_cut[r_row]) ? SIZE_W'(2) : SIZE_W'(1);
    assign w_color = w_col_byte[r_row] ? r_c_fg : r_c_bg;

    // Apply configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= SCREEN_WIDTH_RST;
            r_sh <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCREEN_WIDTH:  r_sw <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_sh <= i_cfg_data;
            endcase
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_busy  <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_s_take) begin
                r_b_valid <= 1'b1;
            end else if (w_b_take) begin
                r_b_valid <= 1'b0;
            end

            // advance the scan, restart it on a new character
            if (w_b_load_c) begin
                r_c_busy <= 1'b1;
                r_col    <= '0;
                r_row    <= '0;
            end else if (w_scan_end) begin
                r_c_busy <= 1'b0;
            end else if (w_step) begin
                if (r_row == ROW_W'(GLYPH_ROWS - 1)) begin
                    r_row <= '0;
                    r_col <= r_col + COL_W'(1);
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end

            if (w_step && w_kept) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Setup: capture the character and read its glyph from the font memory
    always_ff @(posedge i_clk) begin
        if (w_s_take) begin
            r_b_skip   <= w_origin_bad || !w_sel.hit;
            r_b_dbl    <= w_in_dbl;
            r_b_base_x <= w_in_ox + $signed({{(WIDE_W-ORIGIN_W){1'b0}}, w_pitch_off});
            r_b_oy     <= w_in_oy;
            r_b_fg     <= i_s_axis_tdata[67:52];
            r_b_bg     <= i_s_axis_tdata[83:68];
            r_b_glyph  <= GLYPH_ROM[w_sel.idx];
        end
    end

    // Scan context: hold the glyph, colors and clip masks of the character being drawn
    always_ff @(posedge i_clk) begin
        if (w_b_load_c) begin
            r_c_dbl    <= r_b_dbl;
            r_c_x0     <= r_b_base_x[COORD_W-1:0];
            r_c_y0     <= r_b_oy[COORD_W-1:0];
            r_c_fg     <= r_b_fg;
            r_c_bg     <= r_b_bg;
            r_c_glyph  <= r_b_glyph;
            r_col_ok   <= n_col_ok;
            r_col_cut  <= n_col_cut;
            r_col_last <= n_col_last;
            r_row_ok   <= n_row_ok;
            r_row_cut  <= n_row_cut;
            r_row_last <= n_row_last;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_step && w_kept) begin
            r_o_data <= {w_color, w_rh, w_rw, w_py, w_px};
            r_o_last <= r_col_last[r_col] && r_row_last[r_row];
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;

endmodule
`default_nettype wire

// File: bench/glyph_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_write_checker
// Watches the character, rectangle write and register channels of the 5x7
// renderer. Works out the clipped writes each accepted character paints and
// compares every write transfer, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module glyph_write_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // character channel
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    // origin_x, origin_y, char_pos, char_code, fore_color, back_color, pad
    input  wire logic [fgpr_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                           i_s_tuser,   // mode
    // rectangle write channel
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    // rect_x, rect_y, rect_w, rect_h, fill_color
    input  wire logic [fgpr_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  wire logic                           i_m_tlast,   // last
    // register writes
    input  wire logic                           i_cfg_we,
    input  wire logic [fgpr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fgpr_pkg::COORD_W-1:0]   i_cfg_data,
    output logic [31:0]                         o_fail_count,
    output logic [31:0]                         o_writes_due
);
    import fgpr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Normal mode skips a string whose origin lies beyond these
    localparam int LEFT_MARGIN = -30;
    localparam int TOP_MARGIN  = -7;

    // Character codes that pick a glyph group
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    // Font layout: letters, digits, then space through slash, colon, semicolon
    localparam int FONT_DIGIT0 = 26;
    localparam int FONT_SPACE  = 36;
    localparam int FONT_COLON  = 52;
    localparam int FONT_SEMI   = 53;
    localparam int NO_GLYPH    = -1;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [1:0]  w;
        logic [1:0]  h;
        logic [15:0] color;
        logic        last;
    } t_rect_write;

    t_rect_write rect_writes_due[$];
    int          scr_w = 240;
    int          scr_h = 320;
    int          fail_total = 0;

    // Font entry for a code, or none where the mode draws nothing
    function automatic int font_entry_for(input logic [7:0] code, input logic dbl);
        if (code >= CH_UPPER_A && code <= CH_UPPER_Z) return int'(code - CH_UPPER_A);
        if (code >= CH_LOWER_A && code <= CH_LOWER_Z) return int'(code - CH_LOWER_A);
        if (code >= CH_DIGIT0 && code <= CH_DIGIT9)
            return FONT_DIGIT0 + int'(code - CH_DIGIT0);
        if (dbl) return (code == CH_SPACE) ? FONT_SPACE : NO_GLYPH;
        if (code >= CH_SPACE && code <= CH_SLASH) return FONT_SPACE + int'(code - CH_SPACE);
        if (code == CH_COLON) return FONT_COLON;
        if (code == CH_SEMI) return FONT_SEMI;
        return FONT_SPACE;
    endfunction

    // Five column bytes, column 0 in the top byte, row 0 in bit 0
    function automatic logic [39:0] font_columns(input int entry);
        case (entry)
            0:  return 40'h7C1211127C;
            1:  return 40'h7F49494936;
            2:  return 40'h3E41414122;
            3:  return 40'h7F4141221C;
            4:  return 40'h7F49494941;
            5:  return 40'h7F09090901;
            6:  return 40'h3E4149497A;
            7:  return 40'h7F0808087F;
            8:  return 40'h00417F4100;
            9:  return 40'h2040413F01;
            10: return 40'h7F08142241;
            11: return 40'h7F40404040;
            12: return 40'h7F020C027F;
            13: return 40'h7F0408107F;
            14: return 40'h3E4141413E;
            15: return 40'h7F09090906;
            16: return 40'h3E4151215E;
            17: return 40'h7F09192946;
            18: return 40'h4649494931;
            19: return 40'h01017F0101;
            20: return 40'h3F4040403F;
            21: return 40'h1F2040201F;
            22: return 40'h3F4038403F;
            23: return 40'h6314081463;
            24: return 40'h0708700807;
            25: return 40'h6151494543;
            26: return 40'h3E5149453E;
            27: return 40'h00427F4000;
            28: return 40'h4261514946;
            29: return 40'h2141454B31;
            30: return 40'h1814127F10;
            31: return 40'h2745454539;
            32: return 40'h3C4A494930;
            33: return 40'h0171090503;
            34: return 40'h3649494936;
            35: return 40'h064949291E;
            37: return 40'h00005F0000;
            38: return 40'h0007000700;
            39: return 40'h147F147F14;
            40: return 40'h242A7F2A12;
            41: return 40'h2313086462;
            42: return 40'h3649552250;
            43: return 40'h0005030000;
            44: return 40'h001C224100;
            45: return 40'h0041221C00;
            46: return 40'h14083E0814;
            47: return 40'h08083E0808;
            48: return 40'h0050300000;
            49: return 40'h0808080808;
            50: return 40'h0060600000;
            51: return 40'h2010080402;
            52: return 40'h0036360000;
            53: return 40'h0056360000;
            default: return 40'h0000000000;
        endcase
    endfunction

    // Queue the clipped writes that paint one character
    task automatic render_glyph(input logic dbl, input logic [S_TDATA_W-1:0] item);
        int          ox, oy, pos, pitch, size, entry, px, py, w, h, c, r;
        logic [39:0] cols;
        logic [7:0]  colbits;
        logic [15:0] fg, bg;
        t_rect_write wr, held;
        bit          have_held;
        ox = int'($signed(item[15:0]));
        oy = int'($signed(item[31:16]));
        pos = int'(item[43:32]);
        fg = item[67:52];
        bg = item[83:68];
        pitch = dbl ? 12 : 6;
        size = dbl ? 2 : 1;
        have_held = 1'b0;
        if (!dbl && (ox >= scr_w || oy >= scr_h || ox < LEFT_MARGIN || oy < TOP_MARGIN))
            return;
        entry = font_entry_for(item[51:44], dbl);
        if (entry == NO_GLYPH) return;
        cols = font_columns(entry);
        for (c = 0; c < 5; c++) begin
            colbits = cols[8*(4-c) +: 8];
            for (r = 0; r < 7; r++) begin
                px = ox + pos * pitch + c * size;
                py = oy + r * size;
                if (px >= 0 && py >= 0 && px < scr_w && py < scr_h) begin
                    w = (px + size > scr_w) ? scr_w - px : size;
                    h = (py + size > scr_h) ? scr_h - py : size;
                    wr.x = px[9:0];
                    wr.y = py[9:0];
                    wr.w = w[1:0];
                    wr.h = h[1:0];
                    wr.color = colbits[r] ? fg : bg;
                    wr.last = 1'b0;
                    // hold back the newest write so the final one can be marked
                    if (have_held) rect_writes_due.push_back(held);
                    held = wr;
                    have_held = 1'b1;
                end
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            rect_writes_due.push_back(held);
        end
    endtask

    // Compare one write transfer with the oldest write due
    task automatic check_write();
        t_rect_write got, want;
        got.x = i_m_tdata[9:0];
        got.y = i_m_tdata[19:10];
        got.w = i_m_tdata[21:20];
        got.h = i_m_tdata[23:22];
        got.color = i_m_tdata[39:24];
        got.last = i_m_tlast;
        if (rect_writes_due.size() == 0) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("checker: unexpected write x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                         got.x, got.y, got.w, got.h, got.color, got.last);
        end else begin
            want = rect_writes_due.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
                got.h !== want.h || got.color !== want.color || got.last !== want.last) begin
                fail_total++;
                if (fail_total <= REPORT_LIMIT) begin
                    $write("checker: write mismatch at %0t:", $time);
                    $write(" expected x=%0d y=%0d w=%0d h=%0d color=%h last=%b,",
                           want.x, want.y, want.w, want.h, want.color, want.last);
                    $display(" got x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                             got.x, got.y, got.w, got.h, got.color, got.last);
                end
            end
        end
    endtask

    // Track the screen size, predict on each character, check each write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scr_w = int'(SCREEN_WIDTH_RST);
            scr_h = int'(SCREEN_HEIGHT_RST);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SCREEN_WIDTH) scr_w = int'(i_cfg_data);
                else if (i_cfg_idx == CFG_SCREEN_HEIGHT) scr_h = int'(i_cfg_data);
            end
            if (i_m_tvalid && i_m_tready) check_write();
            if (i_s_tvalid && i_s_tready) render_glyph(i_s_tuser, i_s_tdata);
        end
        o_writes_due <= rect_writes_due.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: bench/tb_font_glyph_to_pixel_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_font_glyph_to_pixel_renderer_top
// Drives characters into the 5x7 renderer in bursts while the write side
// stalls on its own pattern, steps through several screen sizes, and lets
// the checker judge every rectangle write.
// ----------------------------------------------------------------------------
module tb_font_glyph_to_pixel_renderer_top;
    import fgpr_pkg::*;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  DRAIN_CYCLES = 12;
    localparam int  LONG_HOLD    = 400;
    localparam bit  MODE_NORMAL  = 1'b0;
    localparam bit  MODE_DOUBLE  = 1'b1;

    typedef enum int {RX_OPEN, RX_COIN, RX_LIGHT, RX_HEAVY} t_rx_style;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = CFG_SCREEN_WIDTH;
    logic [COORD_W-1:0]     cfg_data = '0;
    logic [31:0]            fail_count;
    logic [31:0]            writes_due;

    int  cycle_count = 0;
    int  chars_sent = 0;
    int  burst_left = 0;
    int  cur_w = 240;
    int  cur_h = 320;
    bit  stall_request = 1'b0;

    font_glyph_to_pixel_renderer_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    glyph_write_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_writes_due (writes_due)
    );

    always #6 clk = ~clk;

    // Bound the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stall the write side on a changing pattern, with one long hold-off on request
    initial begin : write_side_pacing
        int        hold_left;
        int        style_left;
        t_rx_style style;
        hold_left = 0;
        style_left = 0;
        style = RX_OPEN;
        forever begin
            @(posedge clk);
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style = t_rx_style'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 200);
                end
                style_left--;
                case (style)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    RX_LIGHT: m_tready <= ($urandom_range(0, 7) != 0);
                    default:  m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // End a burst with a random gap, short or long enough to span a glyph scan
    task automatic sender_pause();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Offer one character and hold it until the transfer
    task automatic send_char(input bit mode, input int ox, input int oy, input int pos,
                             input logic [7:0] code, input logic [15:0] fg,
                             input logic [15:0] bg);
        logic [15:0] ox16, oy16;
        logic [11:0] pos12;
        ox16 = ox[15:0];
        oy16 = oy[15:0];
        pos12 = pos[11:0];
        s_tdata <= {4'b0000, bg, fg, code, pos12, oy16, ox16};
        s_tuser <= mode;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
        sender_pause();
    endtask

    // Drop valid and wait until every write due has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (writes_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Load both screen size registers
    task automatic write_screen(input int w, input int h);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_SCREEN_WIDTH;
        cfg_data <= w[COORD_W-1:0];
        @(posedge clk);
        cfg_idx <= CFG_SCREEN_HEIGHT;
        cfg_data <= h[COORD_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // Character mix: mostly drawable, some punctuation and arbitrary bytes
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'("A") + 8'($urandom_range(0, 25));
            3:       return 8'("a") + 8'($urandom_range(0, 25));
            4, 5:    return 8'("0") + 8'($urandom_range(0, 9));
            6:       return " ";
            7:       return 8'($urandom_range(32, 59));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One string: shared origin, mode and colors, consecutive positions
    task automatic send_string();
        int          len, ox, oy, pos, k;
        bit          mode;
        logic [15:0] fg, bg;
        len = $urandom_range(1, 8);
        mode = 1'($urandom_range(0, 1));
        fg = 16'($urandom_range(0, 16'hFFFF));
        bg = 16'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 4) != 0) begin
            ox = int'($urandom_range(0, cur_w + 40)) - 35;
            oy = int'($urandom_range(0, cur_h + 20)) - 10;
        end else begin
            ox = int'($urandom_range(0, 16'hFFFF));
            oy = int'($urandom_range(0, 16'hFFFF));
        end
        pos = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 30) : $urandom_range(0, 4095);
        for (k = 0; k < len; k++)
            send_char(mode, ox, oy, pos + k, pick_code(), fg, bg);
    endtask

    // New screen size once idle, then strings up to the running total
    task automatic run_phase(input int w, input int h, input int n_chars);
        int target;
        target = chars_sent + n_chars;
        settle();
        write_screen(w, h);
        while (chars_sent < target) send_string();
    endtask

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Hold off the write side while the directed characters go in
        stall_request = 1'b1;

        // Directed characters at the reset screen size of 240 x 320
        send_char(MODE_NORMAL, 0, 0, 0, "A", 16'hFFFF, 16'h0000);
        send_char(MODE_NORMAL, 10, 20, 3, "z", 16'h0000, 16'hFFFF);
        send_char(MODE_DOUBLE, 100, 100, 0, "9", 16'hF800, 16'h07E0);
        send_char(MODE_DOUBLE, 50, 60, 2, " ", 16'h001F, 16'hAAAA);
        // double size draws nothing for punctuation or high codes
        send_char(MODE_DOUBLE, 50, 60, 3, "!", 16'h1234, 16'h5678);
        send_char(MODE_DOUBLE, 0, 0, 0, 8'hFF, 16'h1234, 16'h5678);
        // normal size paints unknown codes as blank cells
        send_char(MODE_NORMAL, 30, 40, 1, 8'hC8, 16'h5555, 16'hA5A5);
        send_char(MODE_NORMAL, 30, 40, 2, 8'h00, 16'h5555, 16'h5A5A);
        send_char(MODE_NORMAL, 30, 40, 3, ":", 16'h8001, 16'h7FFE);
        send_char(MODE_NORMAL, 30, 40, 4, ";", 16'h8001, 16'h7FFE);
        send_char(MODE_NORMAL, 30, 40, 5, "/", 16'h8001, 16'h7FFE);
        send_char(MODE_NORMAL, 30, 40, 6, "@", 16'h8001, 16'h7FFE);
        // string origin out of range in normal size
        send_char(MODE_NORMAL, 240, 0, 0, "B", 16'hFFFF, 16'h0000);
        send_char(MODE_NORMAL, 0, 320, 0, "B", 16'hFFFF, 16'h0000);
        send_char(MODE_NORMAL, -31, 0, 0, "B", 16'hFFFF, 16'h0000);
        send_char(MODE_NORMAL, 0, -8, 0, "B", 16'hFFFF, 16'h0000);
        // lowest accepted origin: nothing visible, then partly visible
        send_char(MODE_NORMAL, -30, -7, 0, "W", 16'hFFFF, 16'h0000);
        send_char(MODE_NORMAL, -30, -3, 5, "M", 16'hFFFF, 16'h0000);
        // last full cell on the right, then one past the edge
        send_char(MODE_NORMAL, 0, 0, 39, "E", 16'hC0C0, 16'h0303);
        send_char(MODE_NORMAL, 0, 0, 40, "E", 16'hC0C0, 16'h0303);
        // double size cut at the right and bottom edges, and off the top left
        send_char(MODE_DOUBLE, 235, 314, 0, "W", 16'hF0F0, 16'h0F0F);
        send_char(MODE_DOUBLE, -5, -3, 0, "8", 16'hF0F0, 16'h0F0F);
        // extreme origins and positions land far off screen
        send_char(MODE_DOUBLE, -32768, 0, 4095, "Q", 16'hFFFF, 16'h0000);
        send_char(MODE_DOUBLE, 32767, -32768, 0, "0", 16'hFFFF, 16'h0000);
        send_char(MODE_NORMAL, 0, 0, 4095, "x", 16'hFFFF, 16'h0000);

        // Random strings across screen sizes
        run_phase(1023, 1023, 55);
        run_phase(13, 9, 40);
        run_phase(1, 1, 25);
        run_phase(0, 37, 12);
        run_phase($urandom_range(1, 1023), $urandom_range(1, 1023), 55);
        run_phase(320, 240, 50);
        run_phase(240, 320, 50);

        settle();
        if (fail_count == 0 && writes_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
